### rtl/svm_pkg.sv
package svm_pkg;

    // Fixed field widths
    localparam int SP_W     = 13;
    localparam int WORD_W   = 32;
    localparam int CFG_W    = 16;
    localparam int ENTRY_W  = 16;
    localparam int OUT_PC_W = 16;

    localparam logic [SP_W-1:0] SP_RESET = 13'd4096;

    // Opcodes
    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_HOST_LO = 6'd30;
    localparam logic [5:0] OP_HOST_HI = 6'd36;
    localparam logic [5:0] OP_EXIT = 6'd37;

    // Configuration register indexes
    localparam logic CFG_ENTRY_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    typedef enum logic [1:0] {
        MODE_EXEC    = 2'd0,
        MODE_HOST_WR = 2'd1,
        MODE_HOST_RD = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_RUN         = 3'd0,
        ST_EXITED      = 3'd1,
        ST_BAD_OP      = 3'd2,
        ST_DIV_ZERO    = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_OP1,
        S_READ2,
        S_OP2,
        S_DIV,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } div_rsp_t;

endpackage

### rtl/svm_if.sv
interface svm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [5:0]         opcode;
    logic signed [31:0] operand;
    logic [11:0]        mem_addr;
    logic [31:0]        mem_data;

    modport source (output valid, mode, opcode, operand, mem_addr, mem_data, input ready);
    modport sink   (input valid, mode, opcode, operand, mem_addr, mem_data, output ready);
endinterface

interface svm_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic signed [31:0] acc_value;
    logic [31:0]        read_data;
    logic [2:0]         status;
    logic signed [31:0] exit_code;

    modport source (output valid, next_pc, acc_value, read_data, status, exit_code,
                    input ready);
    modport sink   (input valid, next_pc, acc_value, read_data, status, exit_code,
                    output ready);
endinterface

### rtl/svm_alu.sv
module svm_alu (
    input  logic [5:0]  op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] r
);
    import svm_pkg::*;

    logic [63:0] prod;

    assign prod = a * b;

    // Combinational binary ops other than DIV and MOD: left operand from the stack, right from acc
    always_comb
    begin
        case (op)
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_AND:  r = a & b;
            OP_EQ:   r = {31'd0, a == b};
            OP_NE:   r = {31'd0, a != b};
            OP_LT:   r = {31'd0, $signed(a) <  $signed(b)};
            OP_GT:   r = {31'd0, $signed(a) >  $signed(b)};
            OP_LE:   r = {31'd0, $signed(a) <= $signed(b)};
            OP_GE:   r = {31'd0, $signed(a) >= $signed(b)};
            OP_SHL:  r = a << b[4:0];
            OP_SHR:  r = $unsigned($signed(a) >>> b[4:0]);
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = prod[31:0];
            default: r = '0;
        endcase
    end
endmodule

### rtl/svm_div.sv
module svm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  svm_pkg::div_req_t  req,
    output svm_pkg::div_rsp_t  rsp
);
    import svm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        mod_reg, mod_next;
    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign rem_sh = {rem_reg[31:0], quo_reg[31]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign fits   = !diff[33];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        mod_next   = mod_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            quo_next   = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
            dsr_next   = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
            neg_q_next = req.dividend[31] ^ req.divisor[31];
            neg_r_next = req.dividend[31];
            mod_next   = req.is_mod;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[32:0] : rem_sh;
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        mod_reg   <= mod_next;
    end

    // Apply signs: quotient by both operands, remainder by the dividend
    always_comb
    begin
        rsp.done = done_reg;
        if (mod_reg)
            rsp.result = neg_r_reg ? 32'd0 - rem_reg[31:0] : rem_reg[31:0];
        else
            rsp.result = neg_q_reg ? 32'd0 - quo_reg : quo_reg;
    end
endmodule

### rtl/stack_vm_execute_unit.sv
// Channel | Dir | Beat carries
// cmd     | in  | mode, opcode, operand, mem_addr, mem_data
// rsp     | out | next_pc, acc_value, read_data, status, exit_code
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A result is presented once its beat passed S_READ, S_OP1 and S_RESP (LEV and SC
// add S_READ2 and S_OP2, a second pass through the single memory read port; DIV and
// MOD wait in S_DIV on the 32-step shared divider), and cmd is ready again in the
// same cycle. One item is in work at a time. After reset a clearing pass writes zero
// to every memory word while cmd is held not ready. A finished result waits in the
// output register; the next beat is accepted meanwhile and completes when it drains.
module stack_vm_execute_unit #(
    parameter int MEM_WORDS = 4096,
    parameter int PC_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [svm_pkg::CFG_W-1:0] cfg_data,
    svm_cmd_if.sink                   cmd,
    svm_rsp_if.source                 rsp
);
    import svm_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    seq_state_t          state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg;
    logic [ENTRY_W-1:0]  entry_pc_reg;
    logic [SP_W-1:0]     stack_top_reg;
    logic [PC_BITS-1:0]  pc_reg, pc_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [SP_W-1:0]     fp_reg, fp_next;
    logic [31:0]         acc_reg, acc_next;
    logic                halted_reg, halted_next;
    logic [31:0]         exit_reg, exit_next;
    status_t             status_reg, status_next;
    logic [31:0]         rdata_reg, rdata_next;
    logic [31:0]         tmp_reg, tmp_next;

    // Latched item
    logic [1:0]          mode_reg;
    logic [5:0]          op_reg;
    logic [31:0]         imm_reg;
    logic [11:0]         maddr_reg;
    logic [31:0]         mdata_reg;

    // Output stage
    logic                out_valid_reg;
    logic [15:0]         out_pc_reg;
    logic [31:0]         out_acc_reg;
    logic [31:0]         out_rdata_reg;
    logic [2:0]          out_status_reg;
    logic [31:0]         out_exit_reg;
    logic                out_load;

    // Memory
    logic [31:0]         mem_array [MEM_WORDS];
    logic [31:0]         mem_q_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [31:0]         wr_data;
    logic [AW-1:0]       rd_addr;

    logic [31:0]         alu_r;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic                div_start;

    logic [PC_BITS-1:0]  pc1;
    logic [PC_BITS-1:0]  pc2;
    logic [SP_W-1:0]     sp_dec;
    logic [SP_W-1:0]     sp_inc;
    logic [SP_W-1:0]     fp_inc;
    logic                is_alu;
    logic                is_div;
    logic [31:0]         lc_word;
    logic [31:0]         sc_mask;
    logic [31:0]         sc_byte;
    logic [31:0]         acc_sext8;

    assign pc1    = pc_reg + PC_BITS'(1);
    assign pc2    = pc_reg + PC_BITS'(2);
    assign sp_dec = sp_reg - SP_W'(1);
    assign sp_inc = sp_reg + SP_W'(1);
    assign fp_inc = fp_reg + SP_W'(1);
    assign is_alu = (op_reg >= OP_OR) && (op_reg <= OP_MOD);
    assign is_div = (op_reg == OP_DIV) || (op_reg == OP_MOD);

    assign lc_word   = mem_q_reg >> {acc_reg[1:0], 3'b000};
    assign sc_mask   = 32'h0000_00FF << {tmp_reg[1:0], 3'b000};
    assign sc_byte   = {24'd0, acc_reg[7:0]} << {tmp_reg[1:0], 3'b000};
    assign acc_sext8 = {{24{acc_reg[7]}}, acc_reg[7:0]};

    svm_alu u_alu (
        .op (op_reg),
        .a  (mem_q_reg),
        .b  (acc_reg),
        .r  (alu_r)
    );

    always_comb
    begin
        div_req.start    = div_start;
        div_req.is_mod   = (op_reg == OP_MOD);
        div_req.dividend = mem_q_reg;
        div_req.divisor  = acc_reg;
    end

    svm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Data and stack memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_array[wr_addr] <= wr_data;
        mem_q_reg <= mem_array[rd_addr];
    end

    // Sequencer: next state, register updates, memory controls
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        fp_next     = fp_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        exit_next   = exit_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        tmp_next    = tmp_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(sp_reg);
        wr_data     = '0;
        rd_addr     = AW'(sp_reg);
        div_start   = 1'b0;
        out_load    = 1'b0;
        cmd.ready   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(MEM_WORDS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    status_next = ST_RUN;
                    rdata_next  = '0;
                    state_next  = S_READ;
                end
            end

            S_READ:
            begin
                if (mode_reg == MODE_HOST_RD)
                    rd_addr = AW'(maddr_reg);
                else if ((op_reg == OP_LI) || (op_reg == OP_LC))
                    rd_addr = AW'(acc_reg >> 2);
                else if (op_reg == OP_LEV)
                    rd_addr = AW'(fp_reg);
                else
                    rd_addr = AW'(sp_reg);
                state_next = S_OP1;
            end

            S_OP1:
            begin
                state_next = S_RESP;
                unique case (mode_reg)
                    MODE_HOST_WR:
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = AW'(maddr_reg);
                        wr_data     = mdata_reg;
                        status_next = halted_reg ? ST_EXITED : ST_RUN;
                    end
                    MODE_HOST_RD:
                    begin
                        rdata_next  = mem_q_reg;
                        status_next = halted_reg ? ST_EXITED : ST_RUN;
                    end
                    MODE_RESTART:
                    begin
                        pc_next     = PC_BITS'(entry_pc_reg);
                        sp_next     = stack_top_reg;
                        fp_next     = stack_top_reg;
                        acc_next    = '0;
                        halted_next = 1'b0;
                        exit_next   = '0;
                    end
                    default:
                    begin
                        if (halted_reg)
                            status_next = ST_EXITED;
                        else if (is_alu)
                        begin
                            if (is_div && (acc_reg == '0))
                                status_next = ST_DIV_ZERO;
                            else if (is_div)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                acc_next = alu_r;
                                sp_next  = sp_inc;
                                pc_next  = pc1;
                            end
                        end
                        else
                        begin
                            case (op_reg) inside
                                OP_LEA:
                                begin
                                    acc_next = ({19'd0, fp_reg} + imm_reg) << 2;
                                    pc_next  = pc2;
                                end
                                OP_IMM:
                                begin
                                    acc_next = imm_reg;
                                    pc_next  = pc2;
                                end
                                OP_JMP:
                                    pc_next = PC_BITS'(imm_reg);
                                OP_CALL:
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(sp_dec);
                                    wr_data = 32'(pc2);
                                    sp_next = sp_dec;
                                    pc_next = PC_BITS'(imm_reg);
                                end
                                OP_JZ:
                                    pc_next = (acc_reg != '0) ? pc2 : PC_BITS'(imm_reg);
                                OP_JNZ:
                                    pc_next = (acc_reg != '0) ? PC_BITS'(imm_reg) : pc2;
                                OP_ENT:
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(sp_dec);
                                    wr_data = {19'd0, fp_reg};
                                    fp_next = sp_dec;
                                    sp_next = sp_dec - imm_reg[SP_W-1:0];
                                    pc_next = pc2;
                                end
                                OP_ADJ:
                                begin
                                    sp_next = sp_reg + imm_reg[SP_W-1:0];
                                    pc_next = pc2;
                                end
                                OP_LEV:
                                begin
                                    tmp_next   = mem_q_reg;
                                    state_next = S_READ2;
                                end
                                OP_LI:
                                begin
                                    acc_next = mem_q_reg;
                                    pc_next  = pc1;
                                end
                                OP_LC:
                                begin
                                    acc_next = {{24{lc_word[7]}}, lc_word[7:0]};
                                    pc_next  = pc1;
                                end
                                OP_SI:
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(mem_q_reg >> 2);
                                    wr_data = acc_reg;
                                    sp_next = sp_inc;
                                    pc_next = pc1;
                                end
                                OP_SC:
                                begin
                                    tmp_next   = mem_q_reg;
                                    sp_next    = sp_inc;
                                    state_next = S_READ2;
                                end
                                OP_PUSH:
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(sp_dec);
                                    wr_data = acc_reg;
                                    sp_next = sp_dec;
                                    pc_next = pc1;
                                end
                                OP_EXIT:
                                begin
                                    exit_next   = mem_q_reg;
                                    halted_next = 1'b1;
                                    status_next = ST_EXITED;
                                end
                                [OP_HOST_LO:OP_HOST_HI]:
                                    status_next = ST_UNSUPPORTED;
                                default:
                                    status_next = ST_BAD_OP;
                            endcase
                        end
                    end
                endcase
            end

            S_READ2:
            begin
                // Return address for a frame leave, target word for a byte store
                if (op_reg == OP_LEV)
                    rd_addr = AW'(fp_inc);
                else
                    rd_addr = AW'(tmp_reg >> 2);
                state_next = S_OP2;
            end

            S_OP2:
            begin
                state_next = S_RESP;
                if (op_reg == OP_LEV)
                begin
                    pc_next = PC_BITS'(mem_q_reg);
                    fp_next = tmp_reg[SP_W-1:0];
                    sp_next = fp_reg + SP_W'(2);
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(tmp_reg >> 2);
                    wr_data  = (mem_q_reg & ~sc_mask) | sc_byte;
                    acc_next = acc_sext8;
                    pc_next  = pc1;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = div_rsp.result;
                    sp_next    = sp_inc;
                    pc_next    = pc1;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Architectural and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            entry_pc_reg  <= '0;
            stack_top_reg <= SP_RESET;
            pc_reg        <= '0;
            sp_reg        <= SP_RESET;
            fp_reg        <= SP_RESET;
            acc_reg       <= '0;
            halted_reg    <= 1'b0;
            exit_reg      <= '0;
            status_reg    <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENTRY_PC:  entry_pc_reg  <= cfg_data;
                    CFG_STACK_TOP: stack_top_reg <= cfg_data[SP_W-1:0];
                    default:       entry_pc_reg  <= entry_pc_reg;
                endcase
            end
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
            fp_reg     <= fp_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
            exit_reg   <= exit_next;
            status_reg <= status_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        tmp_reg   <= tmp_next;
        if (cmd.valid && cmd.ready)
        begin
            mode_reg  <= cmd.mode;
            op_reg    <= cmd.opcode;
            imm_reg   <= cmd.operand;
            maddr_reg <= cmd.mem_addr;
            mdata_reg <= cmd.mem_data;
        end
        if (out_load)
        begin
            out_pc_reg     <= 16'(pc_reg);
            out_acc_reg    <= acc_reg;
            out_rdata_reg  <= rdata_reg;
            out_status_reg <= status_reg;
            out_exit_reg   <= exit_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.next_pc   = out_pc_reg;
    assign rsp.acc_value = out_acc_reg;
    assign rsp.read_data = out_rdata_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.exit_code = out_exit_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_READ))
        else $error("accepted beat did not start a memory read");

    a_halt_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> $past(state_reg == S_OP1))
        else $error("halt set outside the execute step");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divider started with a zero divisor");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response step");
endmodule

### tb/tb_svm_if_note.sv
`timescale 1ns / 100ps
// Channel interfaces come from the RTL file list; this unit only holds shared testbench types.
package tb_svm_pkg;
    typedef struct packed {
        logic [15:0] next_pc;
        logic [31:0] acc_value;
        logic [31:0] read_data;
        logic [2:0]  status;
        logic [31:0] exit_code;
    } vm_result_t;
endpackage

### tb/tb_stack_vm_execute_unit.sv
`timescale 1ns / 100ps
module tb_stack_vm_execute_unit;
    import svm_pkg::*;
    import tb_svm_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    svm_cmd_if cmd ();
    svm_rsp_if rsp ();

    stack_vm_execute_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd.sink),
        .rsp       (rsp.source)
    );

    // Predictor state
    logic [15:0] vm_entry;
    logic [12:0] vm_stack_top;
    logic [15:0] vm_pc;
    logic [12:0] vm_sp;
    logic [12:0] vm_bp;
    logic [31:0] vm_acc;
    logic [31:0] vm_mem [0:4095];
    logic        vm_halted;
    logic [31:0] vm_exit;

    vm_result_t expected_results [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  calm;      // no idling while set

    // Clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] sext_byte(logic [31:0] b);
        return {{24{b[7]}}, b[7:0]};
    endfunction

    // Compute one step of the machine and return its result
    function automatic vm_result_t vm_execute(logic [1:0] mode, logic [5:0] op,
                                              logic [31:0] imm, logic [11:0] maddr,
                                              logic [31:0] mdata);
        vm_result_t res;
        logic [31:0] a, b, r, ua, ub, q, addr, w;
        logic [15:0] pc1, pc2;
        logic [2:0]  st;
        logic [31:0] rd;
        st  = ST_RUN;
        rd  = '0;
        pc1 = vm_pc + 16'd1;
        pc2 = vm_pc + 16'd2;
        if (mode == MODE_HOST_WR)
        begin
            vm_mem[maddr] = mdata;
            st = vm_halted ? ST_EXITED : ST_RUN;
        end
        else if (mode == MODE_HOST_RD)
        begin
            rd = vm_mem[maddr];
            st = vm_halted ? ST_EXITED : ST_RUN;
        end
        else if (mode == MODE_RESTART)
        begin
            vm_pc = vm_entry;
            vm_sp = vm_stack_top;
            vm_bp = vm_stack_top;
            vm_acc = '0;
            vm_halted = 1'b0;
            vm_exit = '0;
        end
        else if (vm_halted)
            st = ST_EXITED;
        else if (op >= OP_OR && op <= OP_MOD)
        begin
            a = vm_mem[vm_sp[11:0]];
            b = vm_acc;
            r = '0;
            if ((op == OP_DIV || op == OP_MOD) && b == 0)
                st = ST_DIV_ZERO;
            else
            begin
                ua = a[31] ? -a : a;
                ub = b[31] ? -b : b;
                case (op)
                    OP_OR:  r = a | b;
                    OP_XOR: r = a ^ b;
                    OP_AND: r = a & b;
                    OP_EQ:  r = (a == b);
                    OP_NE:  r = (a != b);
                    OP_LT:  r = ($signed(a) < $signed(b));
                    OP_GT:  r = ($signed(a) > $signed(b));
                    OP_LE:  r = ($signed(a) <= $signed(b));
                    OP_GE:  r = ($signed(a) >= $signed(b));
                    OP_SHL: r = a << b[4:0];
                    OP_SHR: r = $signed(a) >>> b[4:0];
                    OP_ADD: r = a + b;
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    OP_DIV:
                    begin
                        q = ua / ub;
                        r = (a[31] != b[31]) ? -q : q;
                    end
                    default:
                    begin
                        q = ua % ub;
                        r = a[31] ? -q : q;
                    end
                endcase
                vm_sp = vm_sp + 13'd1;
                vm_acc = r;
                vm_pc = pc1;
            end
        end
        else
        begin
            case (op)
                OP_LEA:
                begin
                    vm_acc = ({19'd0, vm_bp} + imm) << 2;
                    vm_pc = pc2;
                end
                OP_IMM:
                begin
                    vm_acc = imm;
                    vm_pc = pc2;
                end
                OP_JMP: vm_pc = imm[15:0];
                OP_CALL:
                begin
                    vm_sp = vm_sp - 13'd1;
                    vm_mem[vm_sp[11:0]] = {16'd0, pc2};
                    vm_pc = imm[15:0];
                end
                OP_JZ:  vm_pc = (vm_acc != 0) ? pc2 : imm[15:0];
                OP_JNZ: vm_pc = (vm_acc != 0) ? imm[15:0] : pc2;
                OP_ENT:
                begin
                    vm_sp = vm_sp - 13'd1;
                    vm_mem[vm_sp[11:0]] = {19'd0, vm_bp};
                    vm_bp = vm_sp;
                    vm_sp = vm_sp - imm[12:0];
                    vm_pc = pc2;
                end
                OP_ADJ:
                begin
                    vm_sp = vm_sp + imm[12:0];
                    vm_pc = pc2;
                end
                OP_LEV:
                begin
                    vm_sp = vm_bp;
                    vm_bp = vm_mem[vm_sp[11:0]][12:0];
                    vm_sp = vm_sp + 13'd1;
                    vm_pc = vm_mem[vm_sp[11:0]][15:0];
                    vm_sp = vm_sp + 13'd1;
                end
                OP_LI:
                begin
                    vm_acc = vm_mem[vm_acc[13:2]];
                    vm_pc = pc1;
                end
                OP_LC:
                begin
                    vm_acc = sext_byte(vm_mem[vm_acc[13:2]] >> (vm_acc[1:0] * 8));
                    vm_pc = pc1;
                end
                OP_SI:
                begin
                    addr = vm_mem[vm_sp[11:0]];
                    vm_sp = vm_sp + 13'd1;
                    vm_mem[addr[13:2]] = vm_acc;
                    vm_pc = pc1;
                end
                OP_SC:
                begin
                    addr = vm_mem[vm_sp[11:0]];
                    vm_sp = vm_sp + 13'd1;
                    w = vm_mem[addr[13:2]];
                    w = (w & ~(32'hFF << (addr[1:0] * 8))) |
                        ({24'd0, vm_acc[7:0]} << (addr[1:0] * 8));
                    vm_mem[addr[13:2]] = w;
                    vm_acc = sext_byte(vm_acc);
                    vm_pc = pc1;
                end
                OP_PUSH:
                begin
                    vm_sp = vm_sp - 13'd1;
                    vm_mem[vm_sp[11:0]] = vm_acc;
                    vm_pc = pc1;
                end
                OP_EXIT:
                begin
                    vm_exit = vm_mem[vm_sp[11:0]];
                    vm_halted = 1'b1;
                    st = ST_EXITED;
                end
                default: st = (op >= OP_HOST_LO && op <= OP_HOST_HI) ?
                              ST_UNSUPPORTED : ST_BAD_OP;
            endcase
        end
        res.next_pc   = vm_pc;
        res.acc_value = vm_acc;
        res.read_data = rd;
        res.status    = st;
        res.exit_code = vm_exit;
        return res;
    endfunction

    // Random response stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= calm || ($urandom_range(99) >= 8);
    end

    // Compare each response beat with the oldest expectation
    always @(posedge clk)
    begin
        vm_result_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response pc=%h", rsp.next_pc);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r.next_pc !== rsp.next_pc || exp_r.acc_value !== rsp.acc_value ||
                    exp_r.read_data !== rsp.read_data || exp_r.status !== rsp.status ||
                    exp_r.exit_code !== rsp.exit_code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp pc=%h acc=%h rd=%h st=%0d ex=%h",
                                 exp_r.next_pc, exp_r.acc_value, exp_r.read_data,
                                 exp_r.status, exp_r.exit_code,
                                 " got pc=%h acc=%h rd=%h st=%0d ex=%h",
                                 rsp.next_pc, rsp.acc_value, rsp.read_data,
                                 rsp.status, rsp.exit_code);
                end
            end
        end
    end

    // Send one command beat, with optional idle cycles ahead of it
    task automatic send_cmd(logic [1:0] mode, logic [5:0] op, logic [31:0] imm,
                            logic [11:0] maddr, logic [31:0] mdata);
        while (!calm && $urandom_range(99) < 8)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.mode     <= mode;
        cmd.opcode   <= op;
        cmd.operand  <= imm;
        cmd.mem_addr <= maddr;
        cmd.mem_data <= mdata;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        expected_results.push_back(vm_execute(mode, op, imm, maddr, mdata));
    endtask

    task automatic exec_op(logic [5:0] op, logic [31:0] imm);
        send_cmd(MODE_EXEC, op, imm, 12'($urandom), $urandom);
    endtask

    task automatic go_idle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ENTRY_PC)
            vm_entry = val;
        else
            vm_stack_top = val[12:0];
    endtask

    task automatic restart_vm();
        send_cmd(MODE_RESTART, 6'($urandom), $urandom, 12'($urandom), $urandom);
    endtask

    // Directed: a selection of opcodes, extremes, faults, halt and host access
    task automatic test_directed();
        exec_op(OP_IMM, 32'h8000_0000);
        exec_op(OP_PUSH, 0);
        exec_op(OP_IMM, 32'hFFFF_FFFF);
        exec_op(OP_DIV, 0);              // overflow division
        exec_op(OP_PUSH, 0);
        exec_op(OP_IMM, 0);
        exec_op(OP_MOD, 0);              // divide by zero
        exec_op(OP_IMM, 32'h7FFF_FFFF);
        exec_op(OP_SHR, 0);
        exec_op(OP_LEA, 32'hFFFF_FFFF);
        exec_op(OP_PUSH, 0);
        exec_op(OP_IMM, 32'h0000_0180);
        exec_op(OP_SC, 0);
        exec_op(OP_LC, 0);
        exec_op(OP_ENT, 2);
        exec_op(OP_CALL, 32'h0000_FFFF);
        exec_op(OP_LEV, 0);
        exec_op(OP_HOST_LO, 0);
        exec_op(6'd63, 0);               // bad opcode
        exec_op(OP_EXIT, 0);
        exec_op(OP_ADD, 0);              // halted
        send_cmd(MODE_HOST_WR, '0, '0, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(MODE_HOST_RD, '0, '0, 12'hFFF, '0);
        restart_vm();
    endtask

    function automatic logic [5:0] pick_op();
        int p;
        p = $urandom_range(99);
        if (p < 3)
            return 6'($urandom_range(63));
        if (p < 5)
            return OP_EXIT;
        return 6'($urandom_range(OP_MOD));
    endfunction

    // Random programs: mostly well-formed opcodes with sane pointers
    task automatic test_random(int count);
        logic [5:0] op;
        logic [31:0] imm;
        int m;
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 3 && i < count / 2);
            m = $urandom_range(99);
            if (m < 5)
                send_cmd(MODE_HOST_WR, '0, '0, 12'($urandom), $urandom);
            else if (m < 10)
                send_cmd(MODE_HOST_RD, '0, '0, 12'($urandom), '0);
            else if (m < 13 || vm_halted)
                restart_vm();
            else
            begin
                op = pick_op();
                case ($urandom_range(3))
                    0: imm = $urandom;
                    1: imm = $urandom_range(16) - 8;
                    default: imm = $urandom_range(8191);
                endcase
                if (op == OP_IMM && $urandom_range(1))
                    imm = $urandom_range(16383);   // valid byte address
                exec_op(op, imm);
            end
        end
        calm = 0;
    endtask

    task automatic test_config(logic [15:0] entry, logic [15:0] top, int count);
        go_idle();
        write_cfg(CFG_ENTRY_PC, entry);
        write_cfg(CFG_STACK_TOP, top);
        restart_vm();
        test_random(count);
    endtask

    initial begin
        calm = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.mode = '0;
        cmd.opcode = '0;
        cmd.operand = '0;
        cmd.mem_addr = '0;
        cmd.mem_data = '0;
        vm_entry = 16'd0;
        vm_stack_top = 13'd4096;
        vm_pc = '0;
        vm_sp = 13'd4096;
        vm_bp = 13'd4096;
        vm_acc = '0;
        vm_halted = 1'b0;
        vm_exit = '0;
        for (int i = 0; i < 4096; i++)
            vm_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200);
        test_config(16'hFFFF, 16'h0000, 150);
        test_config(16'h1234, 16'h1FFF, 150);
        test_config(16'h0000, 16'd4096, 250);
        go_idle();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
